/* hw/rtl/sdw_pkg.sv */
`default_nettype none

package sdw_pkg;

    // Panel geometry.
    localparam int PANEL_WIDTH  = 240;
    localparam int PANEL_HEIGHT = 320;

    // Field widths of the result transaction.
    localparam int COL_W   = 8;
    localparam int ROW_W   = 9;
    localparam int PIXEL_W = 16;
    localparam int BYTE_W  = 8;

    // Frame store geometry.
    localparam int FRAME_DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

    // Window parameter store: four bytes, start then end, big-endian.
    localparam int PARAM_DEPTH = 4;
    localparam int PARAM_AW    = $clog2(PARAM_DEPTH);
    localparam int PARAM_CNT_W = $clog2(PARAM_DEPTH + 1);

    localparam logic [15:0] COL_TOP = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] ROW_TOP = 16'(PANEL_HEIGHT - 1);

    // Command codes.
    localparam logic [BYTE_W-1:0] CMD_SWRESET = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_CASET   = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_RASET   = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_RAMWR   = 8'h2C;
    localparam logic [BYTE_W-1:0] CMD_MADCTL  = 8'h36;

    localparam int          MADCTL_BGR_BIT = 3;
    localparam logic [BYTE_W-1:0] MISO_IDLE = 8'hFF;

    // Exchange the red and blue fields of an RGB565 word.
    function automatic logic [PIXEL_W-1:0] rb_exchange(input logic [PIXEL_W-1:0] v);
        rb_exchange = {v[4:0], v[10:5], v[15:11]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sdw_ram.sv */
`default_nettype none

module sdw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/spi_display_ram_window_writer_unit.sv */
`default_nettype none

// Channel   Direction  Ports                                              Handshake
// s_        in         s_chip_select_level, s_data_not_command, s_data_byte  s_valid/s_ready
// m_        out        m_miso_byte, m_pixel_written, m_pixel_column,         m_valid/m_ready
//                      m_pixel_row, m_pixel_value, m_frame_cleared
//
// Each input transaction yields one result transaction. Most bytes are accepted and then
// handed off to the output register. A pixel write adds the frame store write between the
// two; a column-set or row-set byte that completes the window adds a read-back, as the four
// parameter bytes come back one per cycle from the parameter RAM, then a window update. After
// reset and after a software reset the frame store is swept to zero with s_ready low. A waiting
// result never blocks the next byte's acceptance, only the hand-off of that byte's result.
module spi_display_ram_window_writer_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_chip_select_level,
    input  wire logic                          s_data_not_command,
    input  wire logic [sdw_pkg::BYTE_W-1:0]    s_data_byte,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [sdw_pkg::BYTE_W-1:0]    m_miso_byte,
    output logic                               m_pixel_written,
    output logic      [sdw_pkg::COL_W-1:0]     m_pixel_column,
    output logic      [sdw_pkg::ROW_W-1:0]     m_pixel_row,
    output logic      [sdw_pkg::PIXEL_W-1:0]   m_pixel_value,
    output logic                               m_frame_cleared
);

    import sdw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WIN_RD,
        ST_WIN_APPLY,
        ST_PIX_WR,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_COLSET,
        OP_ROWSET,
        OP_MADCTL,
        OP_MEMWR
    } op_t;

    state_t                 state_reg;
    op_t                    active_cmd_reg;
    logic [PARAM_CNT_W-1:0] param_count_reg;
    logic [2:0]             rd_cnt_reg;
    logic [31:0]            word_reg;
    logic [COL_W-1:0]       col_start_reg, col_end_reg, cursor_col_reg;
    logic [ROW_W-1:0]       row_start_reg, row_end_reg, cursor_row_reg;
    logic                   swap_rb_reg;
    logic                   high_pending_reg;
    logic [BYTE_W-1:0]      high_byte_reg;
    logic                   clear_pending_reg;
    logic [FRAME_AW-1:0]    clr_addr_reg;
    logic [FRAME_AW-1:0]    pix_addr_reg;

    // Staged result of the transaction in flight.
    logic                   res_written_reg;
    logic [COL_W-1:0]       res_col_reg;
    logic [ROW_W-1:0]       res_row_reg;
    logic [PIXEL_W-1:0]     res_value_reg;
    logic                   res_cleared_reg;

    logic                   m_valid_reg;
    logic                   m_pixel_written_reg;
    logic [COL_W-1:0]       m_pixel_column_reg;
    logic [ROW_W-1:0]       m_pixel_row_reg;
    logic [PIXEL_W-1:0]     m_pixel_value_reg;
    logic                   m_frame_cleared_reg;

    logic                   accept;
    logic                   out_free;

    // Parameter RAM port.
    logic                   prm_we;
    logic [PARAM_AW-1:0]    prm_addr;
    logic [BYTE_W-1:0]      prm_rdata;

    // Frame store port.
    logic                   frm_we;
    logic [FRAME_AW-1:0]    frm_addr;
    logic [PIXEL_W-1:0]     frm_wdata;

    // Window computation from the gathered parameter bytes.
    logic [15:0]            win_lo, win_hi, win_top, win_a, win_b;

    // Pixel path.
    logic [PIXEL_W-1:0]     pix_raw, pix_val;
    logic                   pix_in_window;
    logic [FRAME_AW-1:0]    pix_addr;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_miso_byte     = MISO_IDLE;
    assign m_pixel_written = m_pixel_written_reg;
    assign m_pixel_column  = m_pixel_column_reg;
    assign m_pixel_row     = m_pixel_row_reg;
    assign m_pixel_value   = m_pixel_value_reg;
    assign m_frame_cleared = m_frame_cleared_reg;

    // Parameter bytes are written on acceptance and read back one per cycle while the
    // window is rebuilt. The write lands at the accepting edge, so the read-back that
    // starts on the next cycle always sees it.
    always_comb begin
        prm_we   = 1'b0;
        prm_addr = rd_cnt_reg[PARAM_AW-1:0];
        if (state_reg == ST_IDLE) begin
            prm_addr = param_count_reg[PARAM_AW-1:0];
            prm_we   = accept && !s_chip_select_level && s_data_not_command
                       && (active_cmd_reg == OP_COLSET || active_cmd_reg == OP_ROWSET)
                       && (param_count_reg < PARAM_CNT_W'(PARAM_DEPTH));
        end
    end

    always_comb begin
        frm_we    = 1'b0;
        frm_addr  = pix_addr_reg;
        frm_wdata = res_value_reg;
        case (state_reg)
            ST_CLEAR: begin
                frm_we    = 1'b1;
                frm_addr  = clr_addr_reg;
                frm_wdata = '0;
            end
            ST_PIX_WR: begin
                frm_we = 1'b1;
            end
            default: begin
                frm_we = 1'b0;
            end
        endcase
    end

    // Start and end are swapped if given in reverse, then each is clamped to the panel.
    always_comb begin
        win_a   = word_reg[31:16];
        win_b   = word_reg[15:0];
        win_top = (active_cmd_reg == OP_COLSET) ? COL_TOP : ROW_TOP;
        win_lo  = (win_b < win_a) ? win_b : win_a;
        win_hi  = (win_b < win_a) ? win_a : win_b;
        if (win_lo > win_top) begin
            win_lo = win_top;
        end
        if (win_hi > win_top) begin
            win_hi = win_top;
        end
    end

    always_comb begin
        pix_raw       = {high_byte_reg, s_data_byte};
        pix_val       = swap_rb_reg ? rb_exchange(pix_raw) : pix_raw;
        pix_in_window = (cursor_row_reg <= row_end_reg) && (cursor_col_reg <= col_end_reg);
        pix_addr      = FRAME_AW'(FRAME_AW'(cursor_row_reg) * FRAME_AW'(PANEL_WIDTH))
                        + FRAME_AW'(cursor_col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_CLEAR;
            active_cmd_reg      <= OP_NONE;
            param_count_reg     <= '0;
            rd_cnt_reg          <= '0;
            col_start_reg       <= '0;
            col_end_reg         <= COL_W'(PANEL_WIDTH - 1);
            row_start_reg       <= '0;
            row_end_reg         <= ROW_W'(PANEL_HEIGHT - 1);
            cursor_col_reg      <= '0;
            cursor_row_reg      <= '0;
            swap_rb_reg         <= 1'b0;
            high_pending_reg    <= 1'b0;
            high_byte_reg       <= '0;
            clear_pending_reg   <= 1'b0;
            clr_addr_reg        <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == FRAME_AW'(FRAME_DEPTH - 1)) begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + FRAME_AW'(1);
                    end
                end

                ST_IDLE: begin
                    if (accept) begin
                        res_written_reg <= 1'b0;
                        res_col_reg     <= '0;
                        res_row_reg     <= '0;
                        res_value_reg   <= '0;
                        res_cleared_reg <= 1'b0;
                        state_reg       <= ST_FINISH;

                        if (s_chip_select_level) begin
                            // Not addressed: plain idle reply, no state change.
                        end else if (!s_data_not_command) begin
                            param_count_reg <= '0;
                            case (s_data_byte)
                                CMD_CASET:  active_cmd_reg <= OP_COLSET;
                                CMD_RASET:  active_cmd_reg <= OP_ROWSET;
                                CMD_MADCTL: active_cmd_reg <= OP_MADCTL;
                                CMD_RAMWR: begin
                                    active_cmd_reg   <= OP_MEMWR;
                                    cursor_col_reg   <= col_start_reg;
                                    cursor_row_reg   <= row_start_reg;
                                    high_pending_reg <= 1'b0;
                                end
                                CMD_SWRESET: begin
                                    active_cmd_reg    <= OP_NONE;
                                    col_start_reg     <= '0;
                                    col_end_reg       <= COL_W'(PANEL_WIDTH - 1);
                                    row_start_reg     <= '0;
                                    row_end_reg       <= ROW_W'(PANEL_HEIGHT - 1);
                                    swap_rb_reg       <= 1'b0;
                                    res_cleared_reg   <= 1'b1;
                                    clear_pending_reg <= 1'b1;
                                end
                                default: active_cmd_reg <= OP_NONE;
                            endcase
                        end else begin
                            case (active_cmd_reg)
                                OP_COLSET, OP_ROWSET: begin
                                    // The fourth byte, and every byte after it, rebuilds
                                    // the window from the four stored bytes.
                                    if (param_count_reg < PARAM_CNT_W'(PARAM_DEPTH)) begin
                                        param_count_reg <= param_count_reg + PARAM_CNT_W'(1);
                                    end
                                    if (param_count_reg >= PARAM_CNT_W'(PARAM_DEPTH - 1)) begin
                                        rd_cnt_reg <= '0;
                                        state_reg  <= ST_WIN_RD;
                                    end
                                end
                                OP_MADCTL: begin
                                    swap_rb_reg <= s_data_byte[MADCTL_BGR_BIT];
                                end
                                OP_MEMWR: begin
                                    if (!high_pending_reg) begin
                                        high_byte_reg    <= s_data_byte;
                                        high_pending_reg <= 1'b1;
                                    end else begin
                                        high_pending_reg <= 1'b0;
                                        if (pix_in_window) begin
                                            res_written_reg <= 1'b1;
                                            res_col_reg     <= cursor_col_reg;
                                            res_row_reg     <= cursor_row_reg;
                                            res_value_reg   <= pix_val;
                                            pix_addr_reg    <= pix_addr;
                                            state_reg       <= ST_PIX_WR;
                                        end
                                        // The cursor moves even when the pixel falls
                                        // outside a window that shrank mid-write.
                                        if (cursor_col_reg >= col_end_reg) begin
                                            cursor_col_reg <= col_start_reg;
                                            if (cursor_row_reg >= row_end_reg) begin
                                                cursor_row_reg <= row_start_reg;
                                            end else begin
                                                cursor_row_reg <= cursor_row_reg + ROW_W'(1);
                                            end
                                        end else begin
                                            cursor_col_reg <= cursor_col_reg + COL_W'(1);
                                        end
                                    end
                                end
                                default: begin
                                    // Data with no active command is dropped.
                                end
                            endcase
                        end
                    end
                end

                ST_WIN_RD: begin
                    // Reads are registered: each byte is shifted in on the next count.
                    if (rd_cnt_reg != '0) begin
                        word_reg <= {word_reg[23:0], prm_rdata};
                    end
                    if (rd_cnt_reg == 3'(PARAM_DEPTH)) begin
                        state_reg <= ST_WIN_APPLY;
                    end else begin
                        rd_cnt_reg <= rd_cnt_reg + 3'(1);
                    end
                end

                ST_WIN_APPLY: begin
                    if (active_cmd_reg == OP_COLSET) begin
                        col_start_reg <= win_lo[COL_W-1:0];
                        col_end_reg   <= win_hi[COL_W-1:0];
                    end else begin
                        row_start_reg <= win_lo[ROW_W-1:0];
                        row_end_reg   <= win_hi[ROW_W-1:0];
                    end
                    state_reg <= ST_FINISH;
                end

                ST_PIX_WR: begin
                    state_reg <= ST_FINISH;
                end

                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_pixel_written_reg <= res_written_reg;
                        m_pixel_column_reg  <= res_col_reg;
                        m_pixel_row_reg     <= res_row_reg;
                        m_pixel_value_reg   <= res_value_reg;
                        m_frame_cleared_reg <= res_cleared_reg;
                        if (clear_pending_reg) begin
                            clear_pending_reg <= 1'b0;
                            clr_addr_reg      <= '0;
                            state_reg         <= ST_CLEAR;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    sdw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PARAM_DEPTH)
    ) u_param_ram (
        .aclk  (aclk),
        .we    (prm_we),
        .addr  (prm_addr),
        .wdata (s_data_byte),
        .rdata (prm_rdata)
    );

    sdw_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (frm_we),
        .addr  (frm_addr),
        .wdata (frm_wdata),
        .rdata ()
    );

endmodule

`default_nettype wire

/* tb/tb_spi_display_ram_window_writer_unit.sv */
`timescale 1ns / 1ps

// Self-checking bench for the SPI display RAM window writer. A byte-level model of
// the controller runs alongside the block and produces the expected result for
// every byte that the bench sends. A monitor compares each result transaction with
// the oldest expectation, field by field.
module tb_spi_display_ram_window_writer_unit;
    import sdw_pkg::*;

    localparam int          CLK_HALF           = 5;
    localparam int          RESET_CYCLES       = 10;
    localparam int          DRAIN_CYCLES       = 40;
    localparam int          RANDOM_PHASE_BYTES = 630;
    // The block clears its frame store after reset and after each software reset. The
    // run holds at most five such sweeps and about two thousand bytes, so the cycle
    // limit leaves a wide margin.
    localparam longint      CYCLE_LIMIT        = 2_000_000;

    // Which command the data bytes currently belong to.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COLSET,
        MODE_ROWSET,
        MODE_MADCTL,
        MODE_RAMWR
    } cmd_mode_t;

    // One result transaction, as the block should present it.
    typedef struct packed {
        logic [BYTE_W-1:0]  miso;
        logic               written;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PIXEL_W-1:0] value;
        logic               cleared;
    } byte_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_chip_select_level;
    logic                 s_data_not_command;
    logic [BYTE_W-1:0]    s_data_byte;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_miso_byte;
    logic                 m_pixel_written;
    logic [COL_W-1:0]     m_pixel_column;
    logic [ROW_W-1:0]     m_pixel_row;
    logic [PIXEL_W-1:0]   m_pixel_value;
    logic                 m_frame_cleared;

    spi_display_ram_window_writer_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_chip_select_level (s_chip_select_level),
        .s_data_not_command  (s_data_not_command),
        .s_data_byte         (s_data_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_miso_byte         (m_miso_byte),
        .m_pixel_written     (m_pixel_written),
        .m_pixel_column      (m_pixel_column),
        .m_pixel_row         (m_pixel_row),
        .m_pixel_value       (m_pixel_value),
        .m_frame_cleared     (m_frame_cleared)
    );

    always #CLK_HALF aclk = ~aclk;

    // Controller state as the bench tracks it. The frame store itself is not kept,
    // since no result ever reads it back.
    cmd_mode_t          cmd_mode;
    logic [2:0]         param_cnt;
    logic [7:0]         param_mem [4];
    logic [COL_W-1:0]   win_col_lo, win_col_hi;
    logic [ROW_W-1:0]   win_row_lo, win_row_hi;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic               bgr;
    logic               half_pixel_valid;
    logic [7:0]         hi_byte;

    // Expected results in the order the bytes were sent.
    byte_report_t       pixel_reports_due [$];

    int unsigned        error_count     = 0;
    int unsigned        effective_bytes = 0;
    int unsigned        swreset_budget  = 0;
    int unsigned        src_idle_pct    = 7;
    int unsigned        sink_idle_pct   = 73;
    longint unsigned    cycle_count     = 0;

    // Advances the tracked controller state by one SPI byte and returns the result
    // transaction that the byte must produce.
    function automatic byte_report_t apply_spi_byte(input logic cs, input logic dc,
                                                    input logic [7:0] b);
        byte_report_t r;
        logic [15:0]  lo, hi, t, top, raw, val;
        r      = '0;
        r.miso = MISO_IDLE;
        // A byte sent while chip select is high is not addressed to the panel.
        if (cs) begin
            return r;
        end
        if (!dc) begin
            param_cnt = '0;
            case (b)
                CMD_CASET:  cmd_mode = MODE_COLSET;
                CMD_RASET:  cmd_mode = MODE_ROWSET;
                CMD_MADCTL: cmd_mode = MODE_MADCTL;
                CMD_RAMWR: begin
                    cmd_mode         = MODE_RAMWR;
                    cur_col          = win_col_lo;
                    cur_row          = win_row_lo;
                    half_pixel_valid = 1'b0;
                end
                CMD_SWRESET: begin
                    // The cursor and a half-received pixel survive a software reset.
                    win_col_lo = '0;
                    win_col_hi = COL_TOP[COL_W-1:0];
                    win_row_lo = '0;
                    win_row_hi = ROW_TOP[ROW_W-1:0];
                    bgr        = 1'b0;
                    cmd_mode   = MODE_IDLE;
                    r.cleared  = 1'b1;
                end
                default:    cmd_mode = MODE_IDLE;
            endcase
            return r;
        end
        case (cmd_mode)
            MODE_COLSET, MODE_ROWSET: begin
                // Bytes beyond the fourth are dropped, but each one still
                // recomputes the window from the four that were kept.
                if (param_cnt < 3'd4) begin
                    param_mem[param_cnt[1:0]] = b;
                    param_cnt                 = param_cnt + 3'd1;
                end
                if (param_cnt == 3'd4) begin
                    lo = {param_mem[0], param_mem[1]};
                    hi = {param_mem[2], param_mem[3]};
                    if (hi < lo) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                    top = (cmd_mode == MODE_COLSET) ? COL_TOP : ROW_TOP;
                    if (lo > top) lo = top;
                    if (hi > top) hi = top;
                    if (cmd_mode == MODE_COLSET) begin
                        win_col_lo = lo[COL_W-1:0];
                        win_col_hi = hi[COL_W-1:0];
                    end else begin
                        win_row_lo = lo[ROW_W-1:0];
                        win_row_hi = hi[ROW_W-1:0];
                    end
                end
            end
            MODE_MADCTL: bgr = b[MADCTL_BGR_BIT];
            MODE_RAMWR: begin
                if (!half_pixel_valid) begin
                    hi_byte          = b;
                    half_pixel_valid = 1'b1;
                end else begin
                    half_pixel_valid = 1'b0;
                    raw              = {hi_byte, b};
                    // Only the far edges of the window gate the store.
                    if (cur_row <= win_row_hi && cur_col <= win_col_hi) begin
                        val = raw;
                        if (bgr) begin
                            val[15:11] = raw[4:0];
                            val[4:0]   = raw[15:11];
                        end
                        r.written = 1'b1;
                        r.col     = cur_col;
                        r.row     = cur_row;
                        r.value   = val;
                    end
                    // The cursor runs along the row, then wraps to the next row, and
                    // from the last row back to the first.
                    if (cur_col >= win_col_hi) begin
                        cur_col = win_col_lo;
                        cur_row = (cur_row >= win_row_hi) ? win_row_lo : cur_row + 9'd1;
                    end else begin
                        cur_col = cur_col + 8'd1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sends one byte: records its expected result, idles for a random number of
    // cycles, then holds the transaction until the block accepts it. Valid stays
    // high after acceptance so that back-to-back bytes need no gap.
    task automatic send_byte(input logic cs, input logic dc, input logic [7:0] b);
        if (!cs && (!dc || cmd_mode != MODE_IDLE)) begin
            effective_bytes++;
        end
        pixel_reports_due.push_back(apply_spi_byte(cs, dc, b));
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_chip_select_level <= cs;
        s_data_not_command  <= dc;
        s_data_byte         <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result monitor. Output values are read in the active region right after the
    // edge, so they are the values the block held at that edge. The receiver's
    // ready is redrawn every cycle from the current stall rate.
    always @(posedge aclk) begin : result_monitor
        byte_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_reports_due.size() == 0) begin
                $error("result transaction arrived with no byte awaiting a result");
                error_count++;
            end else begin
                want = pixel_reports_due.pop_front();
                check_field("m_miso_byte",     32'(want.miso),    32'(m_miso_byte));
                check_field("m_pixel_written", 32'(want.written), 32'(m_pixel_written));
                check_field("m_pixel_column",  32'(want.col),     32'(m_pixel_column));
                check_field("m_pixel_row",     32'(want.row),     32'(m_pixel_row));
                check_field("m_pixel_value",   32'(want.value),   32'(m_pixel_value));
                check_field("m_frame_cleared", 32'(want.cleared), 32'(m_frame_cleared));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog for a block that hangs or never answers.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Bytes with chip select high must be answered but change nothing, and a data
    // byte with no command in force is ignored.
    task automatic test_chip_select_ignored();
        send_byte(1'b1, 1'b0, CMD_CASET);
        send_byte(1'b1, 1'b1, 8'hFF);
        send_byte(1'b0, 1'b1, 8'h00);
    endtask

    // Column set with a reversed, out-of-range pair plus one byte too many, then a
    // row set with the largest possible values, which clamp to the last row.
    task automatic test_window_set();
        send_byte(1'b0, 1'b0, CMD_CASET);
        send_byte(1'b0, 1'b1, 8'h01);
        send_byte(1'b0, 1'b1, 8'h00);
        send_byte(1'b0, 1'b1, 8'h00);
        send_byte(1'b0, 1'b1, 8'h05);
        send_byte(1'b0, 1'b1, 8'hAA);
        send_byte(1'b0, 1'b0, CMD_RASET);
        repeat (4) send_byte(1'b0, 1'b1, 8'hFF);
    endtask

    // Red/blue swap switched on, then one pixel written at the window origin.
    task automatic test_memory_write_swap();
        send_byte(1'b0, 1'b0, CMD_MADCTL);
        send_byte(1'b0, 1'b1, 8'(1 << MADCTL_BGR_BIT));
        send_byte(1'b0, 1'b0, CMD_RAMWR);
        send_byte(1'b0, 1'b1, 8'h12);
        send_byte(1'b0, 1'b1, 8'h34);
    endtask

    // A command the block does not act on ends the previous command, so the data
    // byte after it is ignored.
    task automatic test_other_commands();
        send_byte(1'b0, 1'b0, 8'h29);
        send_byte(1'b0, 1'b1, 8'h55);
    endtask

    // Software reset clears the store, the swap flag and the window; the pixel that
    // follows must land at the panel origin without a swap.
    task automatic test_software_reset();
        send_byte(1'b0, 1'b0, CMD_SWRESET);
        send_byte(1'b0, 1'b0, CMD_RAMWR);
        send_byte(1'b0, 1'b1, 8'hF8);
        send_byte(1'b0, 1'b1, 8'h1F);
    endtask

    // Random traffic made mostly of well-formed command sequences with random
    // content: window sets (some cut short or overlong), swap settings, and pixel
    // bursts that wrap around small windows. Noise bytes with chip select high and
    // stray commands are mixed in, and at most one software reset per phase keeps
    // the store-clearing sweeps few.
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct);
        int unsigned goal, pick, n, k;
        logic [15:0] lo, hi, t, top;
        logic [7:0]  cmd;
        logic [7:0]  seq [4];
        src_idle_pct   = src_pct;
        sink_idle_pct  = sink_pct;
        swreset_budget = 1;
        goal           = effective_bytes + RANDOM_PHASE_BYTES;
        while (effective_bytes < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                cmd = $urandom_range(0, 1) ? CMD_CASET : CMD_RASET;
                top = (cmd == CMD_CASET) ? COL_TOP : ROW_TOP;
                if ($urandom_range(0, 3) == 0) begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                end else begin
                    // Small windows anywhere on the panel or just past its far edge.
                    lo = 16'($urandom_range(0, top + 8));
                    hi = lo + 16'($urandom_range(0, 6));
                    if ($urandom_range(0, 3) == 0) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                seq = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
                k   = $urandom_range(0, 9);
                n   = (k == 0) ? $urandom_range(1, 3) : (k == 1) ? $urandom_range(5, 7) : 4;
                send_byte(1'b0, 1'b0, cmd);
                for (k = 0; k < n; k++) begin
                    send_byte(1'b0, 1'b1, (k < 4) ? seq[k] : 8'($urandom));
                end
            end else if (pick < 26) begin
                send_byte(1'b0, 1'b0, CMD_MADCTL);
                repeat ($urandom_range(1, 2)) send_byte(1'b0, 1'b1, 8'($urandom));
            end else if (pick < 80) begin
                // Mostly whole pixels; now and then a burst ends on a lone high byte.
                n = 2 * $urandom_range(1, 24);
                if ($urandom_range(0, 4) == 0) n = n - 1;
                send_byte(1'b0, 1'b0, CMD_RAMWR);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_byte(1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
                    end
                    send_byte(1'b0, 1'b1, 8'($urandom));
                end
            end else if (pick < 94 || swreset_budget == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_byte(1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
                    end
                end else begin
                    cmd = 8'($urandom);
                    if (cmd == CMD_SWRESET) cmd = 8'h00;
                    send_byte(1'b0, 1'b0, cmd);
                    repeat ($urandom_range(0, 2)) send_byte(1'b0, 1'b1, 8'($urandom));
                end
            end else begin
                swreset_budget--;
                send_byte(1'b0, 1'b0, CMD_SWRESET);
            end
        end
    endtask

    initial begin
        aresetn             <= 1'b0;
        s_valid             <= 1'b0;
        s_chip_select_level <= 1'b1;
        s_data_not_command  <= 1'b0;
        s_data_byte         <= '0;

        // The tracked state starts where the block's reset leaves it.
        cmd_mode         = MODE_IDLE;
        param_cnt        = '0;
        win_col_lo       = '0;
        win_col_hi       = COL_TOP[COL_W-1:0];
        win_row_lo       = '0;
        win_row_hi       = ROW_TOP[ROW_W-1:0];
        cur_col          = '0;
        cur_row          = '0;
        bgr              = 1'b0;
        half_pixel_valid = 1'b0;
        hi_byte          = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed bytes run with a slow receiver; the first byte waits out the
        // store-clearing sweep that follows reset.
        test_chip_select_ignored();
        test_window_set();
        test_memory_write_swap();
        test_other_commands();
        test_software_reset();

        // Random phases: slow receiver, then slow sender, then full rate.
        test_random_traffic(7, 73);
        test_random_traffic(73, 7);
        test_random_traffic(0, 0);
        s_valid <= 1'b0;

        // Let every result drain, then watch a little longer for stray results.
        while (pixel_reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sdw_pkg.sv
hw/rtl/sdw_ram.sv
hw/rtl/spi_display_ram_window_writer_unit.sv
tb/tb_spi_display_ram_window_writer_unit.sv
